@@ rtl/vdi_pkg.sv @@
// ----------------------------------------------------------------------------
// vdi_pkg: shared types and codes of the vertex deduplication indexer
// Request codes, controller states and the control/status structs.
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 10;

    typedef enum logic [2:0] {
        REQ_LOAD_POS = 3'd0,
        REQ_LOAD_TEX = 3'd1,
        REQ_LOAD_NRM = 3'd2,
        REQ_TRIPLE   = 3'd3,
        REQ_START    = 3'd4
    } req_t;

    localparam logic [1:0] CFG_USE_POS = 2'd0;
    localparam logic [1:0] CFG_USE_TEX = 2'd1;
    localparam logic [1:0] CFG_USE_NRM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_CHECK,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_pos;
        logic load_tex;
        logic load_nrm;
        logic clear;
        logic capture;
        logic latch_attr;
        logic scan_rd;
        logic scan_adv;
        logic append;
        logic emit;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic hit;
    } sts_t;

endpackage

@@ rtl/vdi_ctrl.sv @@
// ----------------------------------------------------------------------------
// vdi_ctrl: request sequencer
// Decodes requests and walks the unique table one entry at a time, reading it in ST_SCAN and comparing it in ST_CHECK.
// ----------------------------------------------------------------------------
module vdi_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [2:0]    req_type,
    output logic          busy,
    output vdi_pkg::ctl_t ctl,
    input  vdi_pkg::sts_t sts
);
    import vdi_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && req_type == REQ_TRIPLE)
                    state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_end)
                    state_next = ST_DONE;
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.hit)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load_pos = take && req_type == REQ_LOAD_POS;
                ctl.load_tex = take && req_type == REQ_LOAD_TEX;
                ctl.load_nrm = take && req_type == REQ_LOAD_NRM;
                ctl.clear    = take && req_type == REQ_START;
                ctl.capture  = take && req_type == REQ_TRIPLE;
            end
            ST_FETCH: ctl.latch_attr = 1'b1;
            ST_SCAN:  ctl.scan_rd = !sts.scan_end;
            ST_CHECK: ctl.scan_adv = !sts.hit;
            ST_DONE:
            begin
                ctl.emit   = 1'b1;
                ctl.append = !sts.hit;
            end
            default:  ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a hit can only be seen after a table read
    a_hit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> $past(ctl.scan_rd))
        else $error("check without read");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> !ctl.emit)
        else $error("double result");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ctl.capture && !ctl.clear)
        else $error("request taken while busy");

endmodule

@@ rtl/vdi_datapath.sv @@
// ----------------------------------------------------------------------------
// vdi_datapath: attribute stores, unique table and result registers
// Each table entry is 256 bits wide and is read one entry at a time.
// ----------------------------------------------------------------------------
module vdi_datapath
#(
    parameter int ATTR_DEPTH = 1024,
    parameter int MAX_UNIQUE = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  vdi_pkg::ctl_t ctl,
    output vdi_pkg::sts_t sts,
    input  logic          use_position,
    input  logic          use_texcoord,
    input  logic          use_normal,
    input  logic [9:0]    position_slot,
    input  logic [9:0]    texcoord_slot,
    input  logic [9:0]    normal_slot,
    input  logic [31:0]   load_x,
    input  logic [31:0]   load_y,
    input  logic [31:0]   load_z,
    output logic          done,
    output logic [9:0]    unique_index,
    output logic          is_new,
    output logic          table_full,
    output logic [31:0]   pos_x,
    output logic [31:0]   pos_y,
    output logic [31:0]   pos_z,
    output logic [31:0]   tex_u,
    output logic [31:0]   tex_v,
    output logic [31:0]   nrm_x,
    output logic [31:0]   nrm_y,
    output logic [31:0]   nrm_z
);
    import vdi_pkg::*;

    localparam int AW = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
    localparam int UW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int CW = $clog2(MAX_UNIQUE + 1);
    localparam int VW = 8 * WORD_W;

    logic [95:0] pos_mem [ATTR_DEPTH];
    logic [63:0] tex_mem [ATTR_DEPTH];
    logic [95:0] nrm_mem [ATTR_DEPTH];
    logic [VW-1:0] vtx_mem [MAX_UNIQUE];

    logic [95:0]   pos_rd_reg;
    logic [63:0]   tex_rd_reg;
    logic [95:0]   nrm_rd_reg;
    logic [2:0]    en_reg;
    logic [VW-1:0] vtx_reg;
    logic [VW-1:0] tab_rd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_reg;
    logic          hit_flag_reg;
    logic          done_reg;
    logic [IDX_W-1:0] idx_reg;
    logic          new_reg;
    logic          full_reg;
    logic [VW-1:0] out_reg;

    logic          entry_hit;
    logic pos_ok, tex_ok, nrm_ok;
    logic [VW-1:0] vtx_next;

    always_comb
    begin
        pos_ok = {7'd0, position_slot} < 17'(ATTR_DEPTH);
        tex_ok = {7'd0, texcoord_slot} < 17'(ATTR_DEPTH);
        nrm_ok = {7'd0, normal_slot} < 17'(ATTR_DEPTH);
    end

    // attribute stores: write on load, read on triple capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_pos && pos_ok)
            pos_mem[AW'(position_slot)] <= {load_z, load_y, load_x};
        if (ctl.load_tex && tex_ok)
            tex_mem[AW'(texcoord_slot)] <= {load_y, load_x};
        if (ctl.load_nrm && nrm_ok)
            nrm_mem[AW'(normal_slot)] <= {load_z, load_y, load_x};
        if (ctl.capture)
        begin
            pos_rd_reg <= pos_mem[AW'(position_slot)];
            tex_rd_reg <= tex_mem[AW'(texcoord_slot)];
            nrm_rd_reg <= nrm_mem[AW'(normal_slot)];
            en_reg     <= {use_normal && nrm_ok, use_texcoord && tex_ok,
                           use_position && pos_ok};
        end
    end

    // assemble vertex, disabled attributes read as zero
    always_comb
    begin
        vtx_next = '0;
        if (en_reg[0])
            vtx_next[95:0] = pos_rd_reg;
        if (en_reg[1])
            vtx_next[159:96] = tex_rd_reg;
        if (en_reg[2])
            vtx_next[255:160] = nrm_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_attr)
            vtx_reg <= vtx_next;
        if (ctl.scan_rd)
            tab_rd_reg <= vtx_mem[UW'(scan_reg)];
        if (ctl.append && count_reg < CW'(MAX_UNIQUE))
            vtx_mem[UW'(count_reg)] <= vtx_reg;
    end

    assign entry_hit = (tab_rd_reg == vtx_reg);

    // compare live while checking, report the held flag while emitting
    always_comb
    begin
        sts.scan_end = (scan_reg >= count_reg);
        sts.hit      = ctl.emit ? hit_flag_reg : entry_hit;
    end

    // scan pointer, count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_reg     <= '0;
            hit_flag_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
            if (ctl.clear)
                count_reg <= '0;
            else if (ctl.append && count_reg < CW'(MAX_UNIQUE))
                count_reg <= count_reg + 1'b1;
            if (ctl.capture)
            begin
                scan_reg     <= '0;
                hit_flag_reg <= 1'b0;
            end
            else if (ctl.scan_rd)
                hit_flag_reg <= 1'b0;
            else if (ctl.scan_adv)
                scan_reg <= scan_reg + 1'b1;
            else if (!ctl.emit && !ctl.latch_attr && entry_hit && !sts.scan_end)
                hit_flag_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            if (sts.hit)
            begin
                idx_reg  <= IDX_W'(scan_reg);
                new_reg  <= 1'b0;
                full_reg <= 1'b0;
                out_reg  <= '0;
            end
            else if (count_reg >= CW'(MAX_UNIQUE))
            begin
                idx_reg  <= '0;
                new_reg  <= 1'b0;
                full_reg <= 1'b1;
                out_reg  <= '0;
            end
            else
            begin
                idx_reg  <= IDX_W'(count_reg);
                new_reg  <= 1'b1;
                full_reg <= 1'b0;
                out_reg  <= vtx_reg;
            end
        end
    end

    assign done         = done_reg;
    assign unique_index = idx_reg;
    assign is_new       = new_reg;
    assign table_full   = full_reg;
    assign pos_x = out_reg[31:0];
    assign pos_y = out_reg[63:32];
    assign pos_z = out_reg[95:64];
    assign tex_u = out_reg[127:96];
    assign tex_v = out_reg[159:128];
    assign nrm_x = out_reg[191:160];
    assign nrm_y = out_reg[223:192];
    assign nrm_z = out_reg[255:224];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_UNIQUE))
        else $error("count overflow");
    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(new_reg && full_reg))
        else $error("new and full together");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_rd |-> scan_reg < count_reg)
        else $error("scan past count");

endmodule

@@ rtl/vertex_dedup_indexer.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: indexed vertex buffer builder
// Loads attribute stores and answers each vertex triple with a unique index.
//
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+----------------
//  request  | start, busy, req_type, *_slot, load_*     | start & !busy
//  result   | done, unique_index, is_new, table_full,.. | one-cycle strobe
//  config   | cfg_we, cfg_index, cfg_data               | write on cfg_we
//
// Loads and start are taken in ST_IDLE and leave busy low. A triple runs
// through ST_FETCH, then ST_SCAN and ST_CHECK once per entry held until a
// match or the end of the table, then ST_DONE before the result register.
// The unique table is read one 256-bit entry at a time through one port.
// Reset clears the entry count and config to all attributes enabled.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer
#(
    parameter int ATTR_DEPTH = 1024,
    parameter int MAX_UNIQUE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [9:0]  position_slot,
    input  logic [9:0]  texcoord_slot,
    input  logic [9:0]  normal_slot,
    input  logic [31:0] load_x,
    input  logic [31:0] load_y,
    input  logic [31:0] load_z,
    output logic        done,
    output logic [9:0]  unique_index,
    output logic        is_new,
    output logic        table_full,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] tex_u,
    output logic [31:0] tex_v,
    output logic [31:0] nrm_x,
    output logic [31:0] nrm_y,
    output logic [31:0] nrm_z
);
    import vdi_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic use_pos_reg, use_tex_reg, use_nrm_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pos_reg <= 1'b1;
            use_tex_reg <= 1'b1;
            use_nrm_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_USE_POS: use_pos_reg <= cfg_data;
                CFG_USE_TEX: use_tex_reg <= cfg_data;
                CFG_USE_NRM: use_nrm_reg <= cfg_data;
                default:     use_pos_reg <= use_pos_reg;
            endcase
        end
    end

    vdi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .ctl      (ctl),
        .sts      (sts)
    );

    vdi_datapath #(
        .ATTR_DEPTH (ATTR_DEPTH),
        .MAX_UNIQUE (MAX_UNIQUE)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .use_position  (use_pos_reg),
        .use_texcoord  (use_tex_reg),
        .use_normal    (use_nrm_reg),
        .position_slot (position_slot),
        .texcoord_slot (texcoord_slot),
        .normal_slot   (normal_slot),
        .load_x        (load_x),
        .load_y        (load_y),
        .load_z        (load_z),
        .done          (done),
        .unique_index  (unique_index),
        .is_new        (is_new),
        .table_full    (table_full),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .nrm_x         (nrm_x),
        .nrm_y         (nrm_y),
        .nrm_z         (nrm_z)
    );

endmodule
